/* rtl/size_class_free_list_allocator_assert.svh */
// Assertion macros for the size class free list allocator.
// Included by the top level; no other dependencies.
`ifndef SIZE_CLASS_FREE_LIST_ALLOCATOR_ASSERT_SVH
`define SIZE_CLASS_FREE_LIST_ALLOCATOR_ASSERT_SVH
`ifndef SYNTH
`define SCFLA_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("scfla assertion failed");
`define SCFLA_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("scfla assertion failed");
`else
`define SCFLA_ASSERT(lbl, clk, rstn, prop)
`define SCFLA_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

/* rtl/scfla_pkg.sv */
// Shared types, constants and functions of the size class allocator.
// No dependencies.
package scfla_pkg;

  localparam int ADDR_W     = 21;
  localparam int SIZE_W     = 24;
  localparam int CLS_W      = 4;
  localparam int CLS_FULL_W = 5;
  localparam int ST_W       = 2;
  localparam int CFG_W      = 4;
  localparam int LINK_DEPTH = 16 * 1024;
  localparam int LINK_IW    = $clog2(LINK_DEPTH);

  localparam logic [CFG_W-1:0] CFG_RESET = 4'd12;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic [ST_W-1:0] ST_OK        = 2'd0;
  localparam logic [ST_W-1:0] ST_EXHAUSTED = 2'd1;
  localparam logic [ST_W-1:0] ST_TOO_LARGE = 2'd2;

  typedef struct packed {
    logic capture;
    logic commit;
    logic link_rd;
    logic link_commit;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic too_large;
    logic is_free;
    logic head_nz;
  } sts_t;

  // class c covers sizes up to 4 << c; size zero maps to class 0
  function automatic logic [CLS_FULL_W-1:0] size_to_class(input logic [SIZE_W-1:0] size);
    logic [SIZE_W-1:0]     s1;
    logic [CLS_FULL_W-1:0] msb;
    s1  = size - SIZE_W'(1);
    msb = '0;
    for (int i = 0; i < SIZE_W; i++) begin
      if (s1[i]) msb = CLS_FULL_W'(i);
    end
    if (size <= SIZE_W'(4)) return '0;
    return msb - CLS_FULL_W'(1);
  endfunction

endpackage

/* rtl/scfla_ram.sv */
// Generic single-port-write, registered-read RAM.
// No dependencies.
module scfla_ram #(
  parameter int WIDTH = 21,
  parameter int DEPTH = 16384
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* rtl/scfla_ctrl.sv */
// Request sequencing and result handshake of the allocator.
// Depends on scfla_pkg.
module scfla_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  input  scfla_pkg::sts_t     sts,
  output scfla_pkg::cmd_t     cmd
);
  import scfla_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EVAL = 2'd1;
  localparam logic [1:0] S_LINK = 2'd2;

  logic [1:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;
  logic       pop;

  assign out_free = !out_valid_r || !out_stall;
  assign pop      = !sts.too_large && !sts.is_free && sts.head_nz;
  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_EVAL;
        end
      end
      S_EVAL: begin
        if (pop) begin
          cmd.link_rd = 1'b1;
          state_nxt   = S_LINK;
        end else if (out_free) begin
          cmd.commit   = 1'b1;
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      S_LINK: begin
        if (out_free) begin
          cmd.link_commit = 1'b1;
          cmd.load_out    = 1'b1;
          state_nxt       = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

/* rtl/scfla_dp.sv */
// Datapath: request capture, free-list heads, link store, bump pointer, result register.
// Depends on scfla_pkg and scfla_ram.
module scfla_dp #(
  parameter int POOL_BASE   = 4096,
  parameter int POOL_BYTES  = 65536,
  parameter int NUM_CLASSES = 13
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [scfla_pkg::CFG_W-1:0]   cfg_wr_data,
  input  logic                          in_operation,
  input  logic [scfla_pkg::SIZE_W-1:0]  in_request_size,
  input  logic [scfla_pkg::ADDR_W-1:0]  in_block_address,
  input  scfla_pkg::cmd_t               cmd,
  output scfla_pkg::sts_t               sts,
  output logic [scfla_pkg::ADDR_W-1:0]  out_granted_address,
  output logic [scfla_pkg::CLS_W-1:0]   out_size_class,
  output logic [scfla_pkg::ST_W-1:0]    out_status
);
  import scfla_pkg::*;

  localparam int HEAD_IW = $clog2(NUM_CLASSES);
  localparam logic [ADDR_W:0]    POOL_END = (ADDR_W+1)'(POOL_BASE + POOL_BYTES);
  localparam logic [ADDR_W-1:0]  BASE     = ADDR_W'(POOL_BASE);
  localparam logic [CFG_W-1:0]   LIM_CAP  = CFG_W'(NUM_CLASSES + 2);

  logic                  op_r;
  logic [SIZE_W-1:0]     size_r;
  logic [ADDR_W-1:0]     addr_r;
  logic [CFG_W-1:0]      limit_r;
  logic [ADDR_W-1:0]     bump_r, bump_nxt;
  logic [ADDR_W-1:0]     heads_r [NUM_CLASSES];
  logic [ADDR_W-1:0]     gaddr_r;
  logic [CLS_W-1:0]      cls_out_r;
  logic [ST_W-1:0]       status_r;

  logic [CLS_FULL_W-1:0] cls;
  logic [CFG_W-1:0]      lim;
  logic                  too_large;
  logic [HEAD_IW-1:0]    hidx;
  logic                  hidx_ok;
  logic [ADDR_W-1:0]     head;
  logic [ADDR_W:0]       bump_sum;
  logic                  exhausted;
  logic [ADDR_W-1:0]     free_off, head_off;
  logic                  push;
  logic                  bump_take;
  logic [ADDR_W-1:0]     link_rdata;
  logic [ADDR_W-1:0]     res_addr;
  logic [ST_W-1:0]       res_status;

  assign cls       = size_to_class(size_r);
  assign lim       = (limit_r > LIM_CAP) ? LIM_CAP : limit_r;
  assign too_large = ({1'b0, cls} + (CLS_FULL_W+1)'(2)) >= (CLS_FULL_W+1)'(lim);
  assign hidx      = cls[HEAD_IW-1:0];
  assign hidx_ok   = (cls < CLS_FULL_W'(NUM_CLASSES));
  assign head      = hidx_ok ? heads_r[hidx] : '0;
  assign bump_sum  = {1'b0, bump_r} + ((ADDR_W+1)'(4) << cls);
  assign exhausted = bump_sum > POOL_END;
  assign free_off  = addr_r - BASE;
  assign head_off  = head - BASE;

  assign sts.too_large = too_large;
  assign sts.is_free   = (op_r == OP_FREE);
  assign sts.head_nz   = (head != '0);

  assign push      = cmd.commit && !too_large && (op_r == OP_FREE) && (addr_r != '0);
  assign bump_take = cmd.commit && !too_large && (op_r == OP_ALLOC) && (head == '0)
                     && !exhausted;
  assign bump_nxt  = bump_take ? bump_sum[ADDR_W-1:0] : bump_r;

  scfla_ram #(
    .WIDTH (ADDR_W),
    .DEPTH (LINK_DEPTH)
  ) u_link (
    .clk   (clk),
    .we    (push),
    .waddr (free_off[LINK_IW+1:2]),
    .wdata (head),
    .re    (cmd.link_rd),
    .raddr (head_off[LINK_IW+1:2]),
    .rdata (link_rdata)
  );

  always_comb begin
    res_addr   = '0;
    res_status = ST_OK;
    if (too_large) begin
      res_status = ST_TOO_LARGE;
    end else if (op_r == OP_ALLOC) begin
      if (head != '0) begin
        res_addr = head;
      end else if (exhausted) begin
        res_status = ST_EXHAUSTED;
      end else begin
        res_addr = bump_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r   <= in_operation;
      size_r <= in_request_size;
      addr_r <= in_block_address;
    end
    if (cmd.load_out) begin
      gaddr_r   <= res_addr;
      cls_out_r <= too_large ? '0 : cls[CLS_W-1:0];
      status_r  <= res_status;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= CFG_RESET;
      bump_r  <= BASE;
      for (int i = 0; i < NUM_CLASSES; i++) heads_r[i] <= '0;
    end else begin
      if (cfg_wr_en) limit_r <= cfg_wr_data;
      bump_r <= bump_nxt;
      for (int i = 0; i < NUM_CLASSES; i++) begin
        if (hidx_ok && hidx == HEAD_IW'(i)) begin
          if (push) heads_r[i] <= addr_r;
          else if (cmd.link_commit) heads_r[i] <= link_rdata;
        end
      end
    end
  end

  assign out_granted_address = gaddr_r;
  assign out_size_class      = cls_out_r;
  assign out_status          = status_r;

endmodule

/* rtl/size_class_free_list_allocator.sv */
// Top level of the power-of-two size class free list allocator.
// Depends on scfla_pkg, scfla_ctrl, scfla_dp and the assertion header.
//
//   channel  handshake            payload
//   in       in_valid / in_stall  in_operation, in_request_size, in_block_address
//   out      out_valid / out_stall out_granted_address, out_size_class, out_status
//   cfg      cfg_wr_en            cfg_wr_data (small_limit_log2)
//
// Requests are taken one at a time, captured and then evaluated; an allocate that
// pops a free list adds a link state for the registered read of the link store RAM.
// Reset empties every free list and returns the bump pointer to the pool base;
// the link store is not cleared. A stalled result holds the evaluate or link state.
`include "size_class_free_list_allocator_assert.svh"
module size_class_free_list_allocator #(
  parameter int POOL_BASE   = 4096,
  parameter int POOL_BYTES  = 65536,
  parameter int NUM_CLASSES = 13
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [scfla_pkg::CFG_W-1:0]   cfg_wr_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_operation,
  input  logic [scfla_pkg::SIZE_W-1:0]  in_request_size,
  input  logic [scfla_pkg::ADDR_W-1:0]  in_block_address,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [scfla_pkg::ADDR_W-1:0]  out_granted_address,
  output logic [scfla_pkg::CLS_W-1:0]   out_size_class,
  output logic [scfla_pkg::ST_W-1:0]    out_status
);
  import scfla_pkg::*;

  cmd_t cmd;
  sts_t sts;

  scfla_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  scfla_dp #(
    .POOL_BASE   (POOL_BASE),
    .POOL_BYTES  (POOL_BYTES),
    .NUM_CLASSES (NUM_CLASSES)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_wr_en           (cfg_wr_en),
    .cfg_wr_data         (cfg_wr_data),
    .in_operation        (in_operation),
    .in_request_size     (in_request_size),
    .in_block_address    (in_block_address),
    .cmd                 (cmd),
    .sts                 (sts),
    .out_granted_address (out_granted_address),
    .out_size_class      (out_size_class),
    .out_status          (out_status)
  );

  `SCFLA_ASSERT(a_accept_busy, clk, rst_n, in_valid && !in_stall |=> in_stall)
  `SCFLA_ASSERT(a_no_overwrite, clk, rst_n, cmd.load_out |-> !out_valid || !out_stall)
  `SCFLA_ASSERT(a_load_shows, clk, rst_n, cmd.load_out |=> out_valid)
  `SCFLA_ASSERT_ALWAYS(a_too_large_zero, clk,
    out_valid && out_status == ST_TOO_LARGE |-> out_granted_address == '0 && out_size_class == '0)

endmodule
